// ----- rtl/cfl_pkg.sv -----
// cfl_pkg: shared types and constants for the courant time step block
// no dependencies
`timescale 1ns / 1ps

package cfl_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_AW        = 5;

   // register byte addresses
   localparam logic [CSR_AW-1:0] ADDR_SOUND   = 5'd0;
   localparam logic [CSR_AW-1:0] ADDR_COURANT = 5'd4;
   localparam logic [CSR_AW-1:0] ADDR_PHYS    = 5'd8;
   localparam logic [CSR_AW-1:0] ADDR_DIM     = 5'd12;
   localparam logic [CSR_AW-1:0] ADDR_SPHER   = 5'd16;

   localparam logic [1:0] DIM_ONE   = 2'd0;
   localparam logic [1:0] DIM_TWO   = 2'd1;
   localparam logic [1:0] DIM_THREE = 2'd2;

   // classified item handed from front to back
   typedef struct packed {
      logic [31:0] num_mag;     // sound const
      logic [31:0] pres;
      logic [31:0] dens;
      logic [32:0] v1;
      logic [32:0] v2;
      logic [32:0] v3;
      logic [32:0] w1;          // clamped width, non-negative
      logic [63:0] w2;
      logic        bad;
      logic        rel;
      logic [1:0]  mode;
      logic        last;
      logic [15:0] courant;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_DIV, ST_SQRT, ST_RATIO, ST_FOLD, ST_EMIT
   } state_type;

endpackage

// ----- rtl/cfl_front.sv -----
// cfl_front: accepts cells, forms widths with spherical scaling, classifies
// depends on cfl_pkg
`timescale 1ns / 1ps

module cfl_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [31:0]           pressure,
   input  logic [31:0]           density,
   input  logic signed [31:0]    vel_one,
   input  logic signed [31:0]    vel_two,
   input  logic signed [31:0]    vel_three,
   input  logic signed [31:0]    face_one_hi,
   input  logic signed [31:0]    face_one_lo,
   input  logic signed [31:0]    face_two_hi,
   input  logic signed [31:0]    face_two_lo,
   input  logic signed [31:0]    radius,
   input  logic                  last_cell,
   input  logic [31:0]           sound_const,
   input  logic [15:0]           courant,
   input  logic                  physics_mode,
   input  logic [1:0]            dim_mode,
   input  logic                  spherical,
   output logic                  q_valid,
   input  logic                  q_ready,
   output cfl_pkg::item_type     q_item
);
   import cfl_pkg::*;

   // stage one: register raw cell
   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] p_ff, d_ff;
   logic [32:0] a1_ff, a2_ff, a3_ff, mr_ff, m2_ff;
   logic        neg_ff, scale_ff, last_ff;
   logic signed [32:0] d1_ff;
   logic signed [32:0] d2_ff;
   logic [1:0]  mode_ff;
   logic        rel_ff;
   logic [31:0] k_ff;
   logic [15:0] cr_ff;

   logic [1:0]  mode_c;
   logic signed [32:0] d1_c, d2_c;
   logic        s2_valid_ff;
   item_type    s2_ff, s2_in;
   logic        adv2, adv1;

   function automatic logic [32:0] mag33(input logic signed [32:0] x);
      mag33 = x[32] ? 33'(-x) : 33'(x);
   endfunction

   function automatic logic [65:0] a_mul(input logic [32:0] a, input logic [32:0] b);
      a_mul = 66'(a) * 66'(b);
   endfunction

   assign mode_c = (dim_mode == 2'd3) ? DIM_TWO : dim_mode;
   assign d1_c = 33'(face_one_hi) - 33'(face_one_lo);
   assign d2_c = 33'(face_two_hi) - 33'(face_two_lo);

   assign adv2     = !s2_valid_ff || q_ready;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_ready = adv1;
   assign s1_valid_in = adv1 ? in_valid : s1_valid_ff;

   // control for stage one
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else s1_valid_ff <= s1_valid_in;
   end

   // payload for stage one
   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         p_ff     <= pressure;
         d_ff     <= density;
         a1_ff    <= mag33(33'(vel_one));
         a2_ff    <= mag33(33'(vel_two));
         a3_ff    <= mag33(33'(vel_three));
         d1_ff    <= d1_c;
         d2_ff    <= d2_c;
         mr_ff    <= mag33(33'(radius));
         m2_ff    <= mag33(d2_c);
         neg_ff   <= radius[31] ^ d2_c[32];
         scale_ff <= (mode_c != DIM_ONE) && spherical
                     && (mode_c == DIM_THREE || radius != 32'sd0);
         mode_ff  <= mode_c;
         rel_ff   <= physics_mode;
         last_ff  <= last_cell;
         k_ff     <= sound_const;
         cr_ff    <= courant;
      end
   end

   // stage two: radius product and width clamp
   logic [65:0] prod_c;
   logic [65:0] sh_c;
   assign prod_c = a_mul(mr_ff, m2_ff);
   assign sh_c   = prod_c >> FRAC_BITS;

   always_comb begin
      s2_in         = '0;
      s2_in.num_mag = k_ff;
      s2_in.pres    = p_ff;
      s2_in.dens    = d_ff;
      s2_in.v1      = a1_ff;
      s2_in.v2      = a2_ff;
      s2_in.v3      = a3_ff;
      s2_in.w1      = d1_ff[32] ? 33'd0 : 33'(d1_ff);
      if (scale_ff) s2_in.w2 = (neg_ff || sh_c == '0) ? 64'd0 : sh_c[63:0];
      else s2_in.w2 = d2_ff[32] ? 64'd0 : 64'(d2_ff[31:0]);
      s2_in.bad     = (d_ff == 32'd0);
      s2_in.rel     = rel_ff;
      s2_in.mode    = mode_ff;
      s2_in.last    = last_ff;
      s2_in.courant = cr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (adv2) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) s2_ff <= s2_in;
   end

   assign q_valid = s2_valid_ff;
   assign q_item  = s2_ff;

endmodule

// ----- rtl/cfl_queue.sv -----
// cfl_queue: two-entry queue between front and back
// depends on cfl_pkg
`timescale 1ns / 1ps

module cfl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  cfl_pkg::item_type wr_item,
   output logic              rd_valid,
   input  logic              rd_ready,
   output cfl_pkg::item_type rd_item
);
   import cfl_pkg::*;

   item_type  mem_ff [2];
   logic      wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic      wr, rd;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;
   assign rd_item = mem_ff[rp_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_item;
   end

endmodule

// ----- rtl/cfl_back.sv -----
// cfl_back: sound speed, ratios, running minimum and result emit
// depends on cfl_pkg
`timescale 1ns / 1ps

module cfl_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  cfl_pkg::item_type q_item,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [47:0]       time_step,
   output logic              invalid_seen
);
   import cfl_pkg::*;

   localparam logic [47:0] CAP = 48'(64'd100000 << FRAC_BITS);

   state_type st_ff, st_in;
   item_type  it_ff;
   logic [47:0] min_ff, min_in;
   logic        bad_ff, bad_in;
   logic [47:0] ts_ff;
   logic        inv_ff, ov_ff;

   // shared divider / root unit
   logic [111:0] rem_ff;       // divide remainder or sqrt remainder
   logic [111:0] quo_ff;       // quotient or root
   logic [111:0] dvs_ff;       // divisor
   logic [6:0]   cnt_ff;
   logic [111:0] rad_ff;       // sqrt operand
   logic [48:0]  c_ff;
   logic [1:0]   ph_ff;        // ratio index 0..3
   logic [47:0]  rat_ff;

   // ratio selection per phase
   logic [63:0] w_sel;
   logic [32:0] v_sel;
   logic        ph_use;
   always_comb begin
      w_sel = 64'(it_ff.w1); v_sel = it_ff.v1; ph_use = 1'b1;
      unique case (ph_ff)
         2'd0: begin w_sel = 64'(it_ff.w1); v_sel = it_ff.v1; ph_use = 1'b1; end
         2'd1: begin w_sel = 64'(it_ff.w1); v_sel = it_ff.v3;
                     ph_use = (it_ff.mode == DIM_THREE); end
         2'd2: begin w_sel = it_ff.w2; v_sel = it_ff.v2;
                     ph_use = (it_ff.mode != DIM_ONE); end
         default: begin w_sel = it_ff.w2; v_sel = it_ff.v3;
                     ph_use = (it_ff.mode == DIM_THREE); end
      endcase
   end

   logic [49:0]  den_c;
   assign den_c = 50'(v_sel) + 50'(c_ff);

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:  if (q_valid) st_in = ST_MUL;
         ST_MUL:   if (it_ff.bad || it_ff.rel) st_in = ST_FOLD;
                   else st_in = ST_DIV;
         ST_DIV:   if (cnt_ff == 7'd0) st_in = ST_SQRT;
         ST_SQRT:  if (cnt_ff == 7'd0) st_in = ST_RATIO;
         ST_RATIO: if (cnt_ff == 7'd0 && ph_ff == 2'd3) st_in = ST_FOLD;
         ST_FOLD:  st_in = it_ff.last ? ST_EMIT : ST_IDLE;
         ST_EMIT:  if (!ov_ff) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_ready = (st_ff == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
   end

   logic [111:0] sq_t;
   always_comb begin
      sq_t  = (quo_ff << 2) | 112'd1;
   end

   // running minimum update
   always_comb begin
      min_in = min_ff;
      bad_in = bad_ff;
      if (st_ff == ST_FOLD) begin
         if (it_ff.bad) bad_in = 1'b1;
         else if (it_ff.rel) begin
            if (48'(it_ff.w1) < min_in) min_in = 48'(it_ff.w1);
            if (it_ff.mode != DIM_ONE && it_ff.w2[63:48] == '0
                && it_ff.w2[47:0] < min_in) min_in = it_ff.w2[47:0];
         end
      end else if (st_ff == ST_RATIO && cnt_ff == 7'd0 && ph_use) begin
         if (rat_ff < min_in) min_in = rat_ff;
      end else if (st_ff == ST_EMIT && !ov_ff) begin
         min_in = CAP;
         bad_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= CAP; bad_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         min_ff <= min_in;
         bad_ff <= bad_in;
         if (ov_ff && out_ready) ov_ff <= 1'b0;
         else if (st_ff == ST_EMIT && !ov_ff) ov_ff <= 1'b1;
      end
   end

   // datapath: long division and bit-pair square root, one bit a cycle
   logic [63:0] kp_c;
   assign kp_c = it_ff.num_mag * it_ff.pres;
   always_ff @(posedge clock) begin
      unique case (st_ff)
         ST_IDLE: begin
            it_ff <= q_item;
            ph_ff <= 2'd0;
         end
         ST_MUL: begin
            rem_ff <= '0;
            quo_ff <= 112'(kp_c);
            cnt_ff <= 7'd64;
         end
         ST_DIV: begin
            if (cnt_ff != 7'd0) begin
               if ({rem_ff[110:0], quo_ff[63]} >= 112'(it_ff.dens)) begin
                  rem_ff <= {rem_ff[110:0], quo_ff[63]} - 112'(it_ff.dens);
                  quo_ff <= {quo_ff[110:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[110:0], quo_ff[63]};
                  quo_ff <= {quo_ff[110:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 7'd1;
            end else begin
               // radicand q << F, held in a 96-bit window at the top of rad_ff
               rad_ff <= 112'(quo_ff[63:0]) << (FRAC_BITS + 16);
               rem_ff <= '0;
               quo_ff <= '0;
               cnt_ff <= 7'd48;
            end
         end
         ST_SQRT: begin
            if (cnt_ff != 7'd0) begin
               if (((rem_ff << 2) | 112'(rad_ff[111:110])) >= sq_t) begin
                  rem_ff <= ((rem_ff << 2) | 112'(rad_ff[111:110])) - sq_t;
                  quo_ff <= (quo_ff << 1) | 112'd1;
               end else begin
                  rem_ff <= (rem_ff << 2) | 112'(rad_ff[111:110]);
                  quo_ff <= quo_ff << 1;
               end
               rad_ff <= rad_ff << 2;
               cnt_ff <= cnt_ff - 7'd1;
            end else begin
               c_ff   <= 49'(quo_ff[47:0]);
               cnt_ff <= 7'd81;
               rem_ff <= '0;
            end
         end
         ST_RATIO: begin
            if (cnt_ff == 7'd81) begin
               // load phase operands
               rem_ff <= '0;
               quo_ff <= 112'(w_sel) << FRAC_BITS;
               dvs_ff <= 112'(den_c);
               cnt_ff <= 7'd80;
            end else if (cnt_ff != 7'd1 && cnt_ff != 7'd0) begin
               if ({rem_ff[110:0], quo_ff[79]} >= dvs_ff) begin
                  rem_ff <= {rem_ff[110:0], quo_ff[79]} - dvs_ff;
                  quo_ff <= {quo_ff[110:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[110:0], quo_ff[79]};
                  quo_ff <= {quo_ff[110:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 7'd1;
            end else if (cnt_ff == 7'd1) begin
               if ({rem_ff[110:0], quo_ff[79]} >= dvs_ff)
                  quo_ff <= {quo_ff[110:0], 1'b1};
               else quo_ff <= {quo_ff[110:0], 1'b0};
               cnt_ff <= 7'd0;
            end else begin
               ph_ff  <= ph_ff + 2'd1;
               cnt_ff <= 7'd81;
            end
            if (cnt_ff == 7'd1) begin
               if (dvs_ff == '0) rat_ff <= CAP;
               else if (({rem_ff[110:0], quo_ff[79]} >= dvs_ff ?
                          {quo_ff[78:0], 1'b1} : {quo_ff[78:0], 1'b0}) > 80'(48'hFFFFFFFFFFFF))
                  rat_ff <= 48'hFFFFFFFFFFFF;
               else rat_ff <= ({rem_ff[110:0], quo_ff[79]} >= dvs_ff) ?
                              {quo_ff[46:0], 1'b1} : {quo_ff[46:0], 1'b0};
            end
         end
         ST_EMIT: begin
            if (!ov_ff) begin
               ts_ff  <= ((64'(it_ff.courant) * 64'(min_ff)) >> 16) > 64'(48'hFFFFFFFFFFFF)
                         ? 48'hFFFFFFFFFFFF : 48'((64'(it_ff.courant) * 64'(min_ff)) >> 16);
               inv_ff <= bad_ff;
            end
         end
         default: ;
      endcase
   end

   assign out_valid    = ov_ff;
   assign time_step    = ts_ff;
   assign invalid_seen = inv_ff;

endmodule

// ----- rtl/cfl_time_step_min_top.sv -----
// channel   | direction | handshake
// req_      | in        | req_valid / req_ready, one grid cell per item
// rsp_      | out       | rsp_valid / rsp_ready, time step on last cell
// csr_      | in        | apb write/read, pready always high
// a full cell runs the back through accept, product, divide, root
// and four ratio divisions on one shared unit, then a fold
// width-only and zero-density cells go from the product straight to the fold
// a last cell adds an emit state, held while an earlier result waits
// synchronous active-high reset; the front keeps accepting into the queue
// while the back works or a result waits, until queue and front stages fill
// depends on cfl_pkg, cfl_front, cfl_queue, cfl_back
`timescale 1ns / 1ps

module cfl_time_step_min_top #(
   parameter int FRAC_BITS = cfl_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [31:0]                req_pressure,
   input  logic [31:0]                req_density,
   input  logic signed [31:0]         req_vel_one,
   input  logic signed [31:0]         req_vel_two,
   input  logic signed [31:0]         req_vel_three,
   input  logic signed [31:0]         req_face_one_hi,
   input  logic signed [31:0]         req_face_one_lo,
   input  logic signed [31:0]         req_face_two_hi,
   input  logic signed [31:0]         req_face_two_lo,
   input  logic signed [31:0]         req_radius,
   input  logic                       req_last_cell,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [47:0]                rsp_time_step,
   output logic                       rsp_invalid_seen,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [cfl_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import cfl_pkg::*;

   logic [31:0] sound_ff;
   logic [15:0] cour_ff;
   logic        phys_ff, spher_ff;
   logic [1:0]  dim_ff;
   logic        wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sound_ff <= 32'd65536; cour_ff <= 16'd32768;
         phys_ff <= 1'b0; dim_ff <= DIM_TWO; spher_ff <= 1'b0;
      end else if (wr) begin
         unique case (paddr)
            ADDR_SOUND:   sound_ff <= pwdata;
            ADDR_COURANT: cour_ff  <= pwdata[15:0];
            ADDR_PHYS:    phys_ff  <= pwdata[0];
            ADDR_DIM:     dim_ff   <= pwdata[1:0];
            ADDR_SPHER:   spher_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (paddr)
         ADDR_SOUND:   prdata = sound_ff;
         ADDR_COURANT: prdata = 32'(cour_ff);
         ADDR_PHYS:    prdata = 32'(phys_ff);
         ADDR_DIM:     prdata = 32'(dim_ff);
         ADDR_SPHER:   prdata = 32'(spher_ff);
         default:      prdata = 32'd0;
      endcase
   end

   logic     fq_valid, fq_ready, qb_valid, qb_ready;
   item_type fq_item, qb_item;

   cfl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready),
      .pressure(req_pressure), .density(req_density),
      .vel_one(req_vel_one), .vel_two(req_vel_two), .vel_three(req_vel_three),
      .face_one_hi(req_face_one_hi), .face_one_lo(req_face_one_lo),
      .face_two_hi(req_face_two_hi), .face_two_lo(req_face_two_lo),
      .radius(req_radius), .last_cell(req_last_cell),
      .sound_const(sound_ff), .courant(cour_ff), .physics_mode(phys_ff),
      .dim_mode(dim_ff), .spherical(spher_ff),
      .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
   );

   cfl_queue u_queue (
      .clock, .reset,
      .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
      .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_item(qb_item)
   );

   cfl_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset,
      .q_valid(qb_valid), .q_ready(qb_ready), .q_item(qb_item),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .time_step(rsp_time_step), .invalid_seen(rsp_invalid_seen)
   );

`ifndef SYNTHESIS
   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_time_step))
      else $error("result dropped while stalled");
   // queue never passes an item to a busy back end
   a_back_take: assert property (@(posedge clock) disable iff (reset)
      qb_valid && qb_ready |=> !qb_ready)
      else $error("back end took two items in a row");
`endif

endmodule

// ----- sim/cfl_time_step_min_top_tb.sv -----
// cfl_time_step_min_top_tb: self-checking bench for the courant time step block
// drives grid cells and csr writes, predicts each sweep result in a scoreboard class
// depends on cfl_pkg and cfl_time_step_min_top
`timescale 1ns / 1ps

module cfl_time_step_min_top_tb;
   import cfl_pkg::*;

   localparam logic [63:0] CAP_Q     = 64'd100000 << 16;
   localparam logic [63:0] MASK_48   = (64'd1 << 48) - 64'd1;
   localparam int          SETTLE    = 400;
   localparam longint      CYCLE_MAX = 4000000;

   typedef struct {
      logic [31:0] pressure;
      logic [31:0] density;
      logic [31:0] vel_one;
      logic [31:0] vel_two;
      logic [31:0] vel_three;
      logic [31:0] face_one_hi;
      logic [31:0] face_one_lo;
      logic [31:0] face_two_hi;
      logic [31:0] face_two_lo;
      logic [31:0] radius;
      logic        last_cell;
   } cell_type;

   typedef struct {
      logic [47:0] time_step;
      logic        invalid_seen;
   } step_type;

   // sweep predictor and store of expected time steps
   class step_board;
      logic [31:0] sound_k = 32'd65536;
      logic [15:0] courant = 16'd32768;
      logic        phys    = 1'b0;
      logic [1:0]  dim     = DIM_TWO;
      logic        sph     = 1'b0;
      logic [63:0] run_min = CAP_Q;
      logic        bad     = 1'b0;
      step_type    steps_q[$];
      int          errors  = 0;

      task report(string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      function void set_reg(logic [CSR_AW-1:0] addr, logic [31:0] val);
         case (addr)
            ADDR_SOUND:   sound_k = val;
            ADDR_COURANT: courant = val[15:0];
            ADDR_PHYS:    phys    = val[0];
            ADDR_DIM:     dim     = val[1:0];
            ADDR_SPHER:   sph     = val[0];
            default: ;
         endcase
      endfunction

      function logic [63:0] mag(longint v);
         return v < 0 ? 64'(-v) : 64'(v);
      endfunction

      // floor of the root of a q16 value, in q16
      function logic [63:0] root_q(logic [63:0] q);
         logic [95:0] n;
         logic [95:0] t2;
         logic [47:0] r;
         logic [47:0] t;
         n = {16'b0, q, 16'b0};
         r = '0;
         for (int b = 47; b >= 0; b--) begin
            t  = r | (48'd1 << b);
            t2 = {48'b0, t} * {48'b0, t};
            if (t2 <= n) r = t;
         end
         return {16'b0, r};
      endfunction

      function void fold(logic [63:0] v);
         if (v < run_min) run_min = v;
      endfunction

      function void fold_ratio(logic [63:0] w, logic [63:0] vm, logic [63:0] c);
         logic [63:0] den;
         den = vm + c;
         if (den == 0) fold(CAP_Q);
         else fold((w << 16) / den);
      endfunction

      function void note_cell(cell_type c);
         longint      d1, d2, rad;
         logic [63:0] m, w1, w2, snd, v1, v2, v3;
         logic [1:0]  md;
         step_type    s;
         d1  = longint'($signed(c.face_one_hi)) - longint'($signed(c.face_one_lo));
         d2  = longint'($signed(c.face_two_hi)) - longint'($signed(c.face_two_lo));
         rad = longint'($signed(c.radius));
         v1  = mag(longint'($signed(c.vel_one)));
         v2  = mag(longint'($signed(c.vel_two)));
         v3  = mag(longint'($signed(c.vel_three)));
         md  = (dim == 2'd3) ? DIM_TWO : dim;
         // spherical scaling of the second width
         if (md != DIM_ONE && sph && (md == DIM_THREE || rad != 0)) begin
            m  = (mag(rad) * mag(d2)) >> 16;
            d2 = ((rad < 0) != (d2 < 0)) ? -longint'(m) : longint'(m);
         end
         if (c.density == 0) begin
            bad = 1'b1;
         end else begin
            w1 = d1 < 0 ? 64'd0 : 64'(d1);
            w2 = d2 < 0 ? 64'd0 : 64'(d2);
            if (phys) begin
               fold(w1);
               if (md != DIM_ONE) fold(w2);
            end else begin
               snd = root_q((64'(sound_k) * 64'(c.pressure)) / 64'(c.density));
               fold_ratio(w1, v1, snd);
               if (md == DIM_THREE) fold_ratio(w1, v3, snd);
               if (md != DIM_ONE) fold_ratio(w2, v2, snd);
               if (md == DIM_THREE) fold_ratio(w2, v3, snd);
            end
         end
         if (c.last_cell) begin
            m = (64'(courant) * run_min) >> 16;
            if (m > MASK_48) m = MASK_48;
            s.time_step    = m[47:0];
            s.invalid_seen = bad;
            steps_q.push_back(s);
            run_min = CAP_Q;
            bad     = 1'b0;
         end
      endfunction

      task check_step(logic [47:0] ts, logic inv);
         step_type s;
         if (steps_q.size() == 0) begin
            report($sformatf("unexpected result ts=%h inv=%b", ts, inv));
            return;
         end
         s = steps_q.pop_front();
         if (ts !== s.time_step)
            report($sformatf("time_step got %h want %h", ts, s.time_step));
         if (inv !== s.invalid_seen)
            report($sformatf("invalid_seen got %b want %b", inv, s.invalid_seen));
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [31:0]         req_pressure, req_density;
   logic signed [31:0]  req_vel_one, req_vel_two, req_vel_three;
   logic signed [31:0]  req_face_one_hi, req_face_one_lo;
   logic signed [31:0]  req_face_two_hi, req_face_two_lo, req_radius;
   logic                req_last_cell;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [47:0]         rsp_time_step;
   logic                rsp_invalid_seen;
   logic                psel, penable, pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   step_board sb;
   longint    cycles;
   bit        burst;

   cfl_time_step_min_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pressure(req_pressure), .req_density(req_density),
      .req_vel_one(req_vel_one), .req_vel_two(req_vel_two),
      .req_vel_three(req_vel_three),
      .req_face_one_hi(req_face_one_hi), .req_face_one_lo(req_face_one_lo),
      .req_face_two_hi(req_face_two_hi), .req_face_two_lo(req_face_two_lo),
      .req_radius(req_radius), .req_last_cell(req_last_cell),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_time_step(rsp_time_step), .rsp_invalid_seen(rsp_invalid_seen),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_MAX) begin
         $display("FAIL cfl_time_step_min_top");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_step(rsp_time_step, rsp_invalid_seen);
   end

   // result side stalls
   initial begin
      int w;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         w = burst ? 0 : $urandom_range(0, 17);
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         forever begin
            @(posedge clock);
            if (rsp_valid) break;
         end
         @(negedge clock);
      end
   end

   task csr_write(logic [CSR_AW-1:0] addr, logic [31:0] val);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.set_reg(addr, val);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task write_all(logic [31:0] k, logic [15:0] cr, logic ph, logic [1:0] dm, logic sp);
      csr_write(ADDR_SOUND, k);
      csr_write(ADDR_COURANT, {16'b0, cr});
      csr_write(ADDR_PHYS, {31'b0, ph});
      csr_write(ADDR_DIM, {30'b0, dm});
      csr_write(ADDR_SPHER, {31'b0, sp});
   endtask

   // one cell through the request channel, called at a falling edge
   task send_cell(cell_type c);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pressure    <= c.pressure;
      req_density     <= c.density;
      req_vel_one     <= c.vel_one;
      req_vel_two     <= c.vel_two;
      req_vel_three   <= c.vel_three;
      req_face_one_hi <= c.face_one_hi;
      req_face_one_lo <= c.face_one_lo;
      req_face_two_hi <= c.face_two_hi;
      req_face_two_lo <= c.face_two_lo;
      req_radius      <= c.radius;
      req_last_cell   <= c.last_cell;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      sb.note_cell(c);
      @(negedge clock);
   endtask

   // wait for every expected step, then let the back drain
   task drain;
      req_valid <= 1'b0;
      while (sb.steps_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   function logic [31:0] rand_word(bit pos);
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = $urandom_range(0, 32'h000f_ffff);
         2: v = -$urandom_range(0, 32'h000f_ffff);
         3: case ($urandom_range(0, 4))
               0: v = 32'h0;
               1: v = 32'h1;
               2: v = 32'h7fff_ffff;
               3: v = 32'h8000_0000;
               default: v = 32'hffff_ffff;
            endcase
         default: v = $urandom_range(0, 32'h00ff_ffff);
      endcase
      if (pos && $urandom_range(0, 3) != 0) v = {1'b0, v[30:0]};
      return v;
   endfunction

   function cell_type rand_cell(bit lst);
      cell_type c;
      logic [31:0] span;
      c.pressure  = rand_word(1);
      c.density   = ($urandom_range(0, 24) == 0) ? 32'd0 : rand_word(1);
      if (c.density == 0 && $urandom_range(0, 1)) c.density = $urandom_range(1, 32'hffff);
      c.vel_one   = rand_word(0);
      c.vel_two   = rand_word(0);
      c.vel_three = rand_word(0);
      // mostly ordered faces, some inverted or wild
      if ($urandom_range(0, 7) == 0) begin
         c.face_one_hi = $urandom; c.face_one_lo = $urandom;
         c.face_two_hi = $urandom; c.face_two_lo = $urandom;
      end else begin
         span = $urandom_range(0, 32'h0004_0000);
         c.face_one_lo = rand_word(0);
         c.face_one_hi = c.face_one_lo + ($urandom_range(0, 9) == 0 ? -span : span);
         span = $urandom_range(0, 32'h0004_0000);
         c.face_two_lo = rand_word(0);
         c.face_two_hi = c.face_two_lo + ($urandom_range(0, 9) == 0 ? -span : span);
      end
      c.radius    = ($urandom_range(0, 5) == 0) ? 32'd0 : rand_word(0);
      c.last_cell = lst;
      return c;
   endfunction

   // main sequence
   initial begin
      cell_type c;
      int       n;
      sb       = new();
      cycles   = 0;
      burst    = 1'b0;
      reset    = 1'b1;
      req_valid = 1'b0;
      {req_pressure, req_density, req_vel_one, req_vel_two, req_vel_three} = '0;
      {req_face_one_hi, req_face_one_lo, req_face_two_hi, req_face_two_lo} = '0;
      req_radius = '0; req_last_cell = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, extremes and special cases
      c = '{32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
            32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0, 32'h0, 1'b1};
      send_cell(c);
      c = '{32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
            32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 1'b1};
      send_cell(c);                                   // zero denominator
      c = '{32'hffff_ffff, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
            32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
            32'hffff_ffff, 1'b1};
      send_cell(c);                                   // zero density
      c = '{32'hffff_ffff, 32'h1, 32'h8000_0000, 32'h7fff_ffff, 32'h1,
            32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
            32'h8000_0000, 1'b0};
      send_cell(c);                                   // inverted first width
      c = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h8000_0000,
            32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
            32'h7fff_ffff, 1'b1};
      send_cell(c);                                   // widest widths
      drain();
      write_all(32'hffff_ffff, 16'hffff, 1'b0, DIM_THREE, 1'b1);
      c = '{32'h0004_0000, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000, 32'h0002_0000,
            32'h0003_0000, 32'h0001_0000, 32'h0004_0000, 32'h0001_0000, 32'h0, 1'b0};
      send_cell(c);                                   // zero radius, always scaled
      c = '{32'h0004_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
            32'h0003_0000, 32'h0001_0000, 32'h0004_0000, 32'h0001_0000,
            32'hfffe_0000, 1'b1};
      send_cell(c);                                   // negative radius
      drain();
      write_all(32'h0, 16'h0, 1'b1, 2'd3, 1'b1);
      c = '{32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
            32'h0005_0000, 32'h0001_0000, 32'h0004_0000, 32'h0001_0000, 32'h0, 1'b1};
      send_cell(c);                                   // unused dim, radius zero
      drain();
      write_all(32'h0001_0000, 16'h8000, 1'b1, DIM_ONE, 1'b1);
      c = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
            32'h0005_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 1'b1};
      send_cell(c);                                   // zero density, width only
      c = '{32'h0, 32'h1, 32'h0, 32'h0, 32'h0,
            32'h0000_0002, 32'h0000_0001, 32'h0, 32'h0001_0000, 32'h0, 1'b1};
      send_cell(c);
      drain();

      // random phases over a spread of settings
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: write_all(32'h0001_0000, 16'h8000, 1'b0, DIM_TWO, 1'b0);
            1: write_all(32'hffff_ffff, 16'hffff, 1'b0, DIM_THREE, 1'b1);
            2: write_all(32'h0, 16'h0, 1'b1, DIM_ONE, 1'b0);
            3: write_all($urandom, 16'($urandom), 1'b0, DIM_ONE, 1'b1);
            4: write_all($urandom, 16'($urandom), 1'b1, DIM_TWO, 1'b1);
            5: write_all($urandom, 16'hffff, 1'b0, 2'd3, 1'b1);
            6: write_all(32'h0000_0001, 16'($urandom), 1'b1, DIM_THREE, 1'b1);
            7: write_all($urandom_range(0, 32'h0010_0000), 16'($urandom), 1'b0,
                         DIM_THREE, 1'b0);
            8: write_all($urandom, 16'($urandom), 1'b0, DIM_TWO, 1'b1);
            default: write_all($urandom, 16'($urandom), 1'($urandom_range(0, 1)),
                               2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         endcase
         burst = (ph % 4 == 3);
         n = 200;
         for (int i = 0; i < n; i++) begin
            if (!burst && $urandom_range(0, 39) == 0) burst = 1'b1;
            else if (burst && ph % 4 != 3 && $urandom_range(0, 9) == 0) burst = 1'b0;
            send_cell(rand_cell(i == n - 1 || $urandom_range(0, 7) == 0));
         end
         burst = 1'b0;
         drain();
      end

      if (sb.errors == 0 && sb.steps_q.size() == 0) begin
         $display("PASS cfl_time_step_min_top");
      end else begin
         $display("FAIL cfl_time_step_min_top");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/cfl_pkg.sv
rtl/cfl_front.sv
rtl/cfl_queue.sv
rtl/cfl_back.sv
rtl/cfl_time_step_min_top.sv
sim/cfl_time_step_min_top_tb.sv
